// ===== rtl/met_pkg.sv =====
// Package for the fixed-point Mandelbrot escape-time core.
// Holds widths, register indexes, reset values, the controller state type and
// the command and status structs between the controller and the datapath.
package met_pkg;

    // Default parameter values for the top level.
    localparam int DEF_FRAC_BITS   = 28;
    localparam int DEF_COUNT_WIDTH = 16;

    // Fixed widths of the point coordinates, registers and iteration counter.
    localparam int DATA_W     = 32;
    localparam int LIMIT_W    = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_BAILOUT    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ITER_LIMIT = 1'd1;

    // Reset value of the iteration limit register.
    localparam logic [LIMIT_W-1:0] ITER_LIMIT_RESET = 16'd256;

    // Saturation bounds of a signed coordinate.
    localparam logic [DATA_W-1:0] S32_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] S32_MIN = 32'h8000_0000;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT_MUL,
        ST_INIT_SQ,
        ST_TEST_MUL,
        ST_UPDATE,
        ST_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_point;
        logic mul_en;
        logic load_init_sq;
        logic update;
        logic load_result;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic iterate;
    } t_status;

endpackage

// ===== rtl/met_datapath.sv =====
// Datapath of the Mandelbrot escape-time core: configuration registers,
// point and z registers, three multipliers (two squares and the cross product),
// saturation and counter. Depends on met_pkg.
module met_datapath import met_pkg::*; #(
    parameter int FRAC_BITS   = DEF_FRAC_BITS,
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic signed [DATA_W-1:0] i_c_real,
    input  logic signed [DATA_W-1:0] i_c_imag,
    input  t_cmd                   i_cmd,
    output t_status                o_status,
    output logic [COUNT_WIDTH-1:0] o_iteration_count
);

    // Width of a square after dropping the fraction bits.
    localparam int SQ_W = 2 * DATA_W - FRAC_BITS;
    // Width of the cross product after dividing by 2^(FRAC_BITS-1).
    localparam int XS_W = 2 * DATA_W - FRAC_BITS + 1;
    // Width of r2 - i2 + c_real.
    localparam int ZR_W = DATA_W + 3;
    // Reset value of the bailout register: 4.0, saturated to 32 bits.
    localparam logic [63:0] BAIL_FULL = 64'd4 << FRAC_BITS;
    localparam logic [DATA_W-1:0] BAIL_RESET =
        (BAIL_FULL > 64'hFFFF_FFFF) ? '1 : BAIL_FULL[DATA_W-1:0];

    logic [DATA_W-1:0]          r_bailout;
    logic [LIMIT_W-1:0]         r_iter_limit;
    logic signed [DATA_W-1:0]   r_cr, r_ci, r_zr, r_zi;
    logic signed [2*DATA_W-1:0] r_prod_rr, r_prod_ii, r_prod_ri;
    logic [DATA_W-1:0]          r_r2, r_i2;
    logic [LIMIT_W-1:0]         r_count;
    logic [COUNT_WIDTH-1:0]     r_result;

    logic [SQ_W-1:0]            sq_r_full, sq_i_full;
    logic [DATA_W-1:0]          sq_r, sq_i;
    logic signed [XS_W-1:0]     cross_sh;
    logic signed [XS_W:0]       zi_sum;
    logic signed [ZR_W-1:0]     zr_sum;
    logic [XS_W-DATA_W+1:0]     zi_hi;
    logic [ZR_W-DATA_W:0]       zr_hi;
    logic [DATA_W-1:0]          n_zr, n_zi;
    logic [DATA_W:0]            mag;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bailout    <= BAIL_RESET;
            r_iter_limit <= ITER_LIMIT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_BAILOUT:    r_bailout    <= i_cfg_data[DATA_W-1:0];
                CFG_ITER_LIMIT: r_iter_limit <= i_cfg_data[LIMIT_W-1:0];
            endcase
        end
    end

    // Squares: drop the fraction bits and saturate to an unsigned 32-bit value.
    assign sq_r_full = r_prod_rr[2*DATA_W-1:FRAC_BITS];
    assign sq_i_full = r_prod_ii[2*DATA_W-1:FRAC_BITS];
    assign sq_r = (|sq_r_full[SQ_W-1:DATA_W]) ? '1 : sq_r_full[DATA_W-1:0];
    assign sq_i = (|sq_i_full[SQ_W-1:DATA_W]) ? '1 : sq_i_full[DATA_W-1:0];

    // New imaginary part: floor(zr*zi / 2^(FRAC_BITS-1)) + c_imag, saturated.
    assign cross_sh = $signed(r_prod_ri[2*DATA_W-1:FRAC_BITS-1]);
    assign zi_sum   = (XS_W+1)'(cross_sh) + (XS_W+1)'(r_ci);
    assign zi_hi    = zi_sum[XS_W:DATA_W-1];
    assign n_zi = (&zi_hi || ~|zi_hi) ? zi_sum[DATA_W-1:0]
                : (zi_sum[XS_W] ? S32_MIN : S32_MAX);

    // New real part: r2 - i2 + c_real, saturated.
    assign zr_sum = $signed({3'b000, sq_r}) - $signed({3'b000, sq_i})
                  + ZR_W'(r_cr);
    assign zr_hi  = zr_sum[ZR_W-1:DATA_W-1];
    assign n_zr = (&zr_hi || ~|zr_hi) ? zr_sum[DATA_W-1:0]
                : (zr_sum[ZR_W-1] ? S32_MIN : S32_MAX);

    // Loop test on the squares of the previous pass and on the count.
    assign mag = {1'b0, r_r2} + {1'b0, r_i2};
    assign o_status.iterate = (mag < {1'b0, r_bailout}) && (r_count < r_iter_limit);

    // Point, z and count registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_point) begin
            r_cr    <= i_c_real;
            r_ci    <= i_c_imag;
            r_zr    <= i_c_real;
            r_zi    <= i_c_imag;
            r_count <= '0;
        end else if (i_cmd.update) begin
            r_zr    <= $signed(n_zr);
            r_zi    <= $signed(n_zi);
            r_count <= r_count + 1'b1;
        end
    end

    // Squares of z, kept for the next loop test.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_init_sq || i_cmd.update) begin
            r_r2 <= sq_r;
            r_i2 <= sq_i;
        end
    end

    // Product registers behind the three multipliers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod_rr <= r_zr * r_zr;
            r_prod_ii <= r_zi * r_zi;
            r_prod_ri <= r_zr * r_zi;
        end
    end

    // Result register in front of the output channel.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_result) begin
            r_result <= COUNT_WIDTH'(r_count);
        end
    end

    assign o_iteration_count = r_result;

endmodule

// ===== rtl/met_controller.sv =====
// Controller of the Mandelbrot escape-time core: sequences one point through
// setup and the iteration loop and owns both channel handshakes.
// Depends on met_pkg.
module met_controller import met_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   slot_free;

    assign slot_free = !r_out_valid || i_out_ready;

    // State and output-valid registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:     if (i_in_valid) n_state = ST_INIT_MUL;
            ST_INIT_MUL: n_state = ST_INIT_SQ;
            ST_INIT_SQ:  n_state = ST_TEST_MUL;
            ST_TEST_MUL: n_state = i_status.iterate ? ST_UPDATE : ST_DONE;
            ST_UPDATE:   n_state = ST_TEST_MUL;
            ST_DONE:     if (slot_free) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // Commands and handshake outputs.
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready       = 1'b1;
                o_cmd.load_point = i_in_valid;
            end
            ST_INIT_MUL: o_cmd.mul_en       = 1'b1;
            ST_INIT_SQ:  o_cmd.load_init_sq = 1'b1;
            ST_TEST_MUL: o_cmd.mul_en       = 1'b1;
            ST_UPDATE:   o_cmd.update       = 1'b1;
            ST_DONE:     o_cmd.load_result  = slot_free;
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    // The result slot fills on a load and empties when the transaction completes.
    always_comb begin
        if (o_cmd.load_result) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    // At most one datapath command is issued in any cycle.
    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.load_point, o_cmd.mul_en, o_cmd.load_init_sq,
                  o_cmd.update, o_cmd.load_result}))
        else $error("controller issued more than one command");

    // An accepted point always starts with the setup multiply.
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == ST_INIT_MUL))
        else $error("accepted point did not start setup");

    // A result is never loaded over one that has not been taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_result |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten");

    // Every z update follows a passing loop test.
    a_update_after_test: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TEST_MUL && i_status.iterate) |=> (r_state == ST_UPDATE))
        else $error("loop test passed without an update");

endmodule

// ===== rtl/mandelbrot_escape_time_core.sv =====
// Mandelbrot escape-time core: top level joining the controller and datapath.
// Depends on met_pkg, met_controller and met_datapath.
//
// One point c (signed fixed point, FRAC_BITS fraction bits) is accepted when the
// core is idle and iterated z = z^2 + c from z = c, with every intermediate
// saturating. Each pass first tests the squares from the previous pass against
// the bailout register and the count against the iteration limit. In each pass
// z goes first through the three 32x32 multipliers into their product
// registers and then through the saturate and add stage that forms the next z.
// The result sits in an output register, so the next point is accepted while
// the count still waits to be taken. The user must write the registers
// through the plain write port only while the core is idle; the block itself
// does not enforce it. Index 0 is the bailout threshold on r2 + i2 (reset
// 4.0), index 1 the iteration limit (reset 256).
module mandelbrot_escape_time_core import met_pkg::*; #(
    parameter int FRAC_BITS   = DEF_FRAC_BITS,
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic signed [DATA_W-1:0] i_c_real,
    input  logic signed [DATA_W-1:0] i_c_imag,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [COUNT_WIDTH-1:0]   o_iteration_count
);

    t_cmd    cmd;
    t_status status;

    // Sequencing and handshakes.
    met_controller u_controller (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // Arithmetic, configuration and result storage.
    met_datapath #(
        .FRAC_BITS   (FRAC_BITS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_c_real          (i_c_real),
        .i_c_imag          (i_c_imag),
        .i_cmd             (cmd),
        .o_status          (status),
        .o_iteration_count (o_iteration_count)
    );

endmodule
